[hw/rtl/spibfr_pkg.sv]
// Package for the SPI burst frame reassembler: beat payload structs,
// status codes, header field positions and the byte-swap function.
// No dependencies.
package spibfr_pkg;

    localparam int WORD_W     = 64;
    localparam int SLOT_IN_W  = 7;
    localparam int RWORD_IN_W = 2;
    localparam int LOST_W     = 8;

    // Header fields after the byte swap.
    localparam int HDR_WRITE_BIT = 63;
    localparam int HDR_ADDR_HI   = 62;
    localparam int HDR_ADDR_LO   = 56;

    localparam logic [LOST_W-1:0] LOST_MAX = 8'hFF;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_READ    = 2'd3;

    localparam logic OP_BURST = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [WORD_W-1:0]     header_raw;
        logic [WORD_W-1:0]     data_raw_a;
        logic [WORD_W-1:0]     data_raw_b;
        logic [WORD_W-1:0]     data_raw_c;
        logic [WORD_W-1:0]     data_raw_d;
        logic [SLOT_IN_W-1:0]  read_slot;
        logic [RWORD_IN_W-1:0] read_word;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              frame_done;
        logic [LOST_W-1:0] frame_lost;
        logic              frame_ready;
        logic [WORD_W-1:0] read_data;
        logic              read_present;
    } rsp_t;

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        for (int k = 0; k < WORD_W / 8; k++) begin
            r[8*k +: 8] = v[WORD_W - 8*(k+1) +: 8];
        end
        return r;
    endfunction

endpackage

[hw/rtl/spi_burst_frame_reassembler.sv]
// SPI burst frame reassembler: control registers, presence bits, the
// double-banked frame word memory and the result register.
// Depends on spibfr_pkg.
//
//  channel | valid     | stall     | payload | beat
//  --------+-----------+-----------+---------+------------------------------------
//  request | req_valid | req_stall | req     | one burst or one frame word read
//  result  | rsp_valid | rsp_stall | rsp     | one result for every request beat
//
// A result appears the cycle after its request beat; reads are taken every cycle
// unless a stalled result holds them. A stored burst writes WORDS_PER_SLOT words,
// one per cycle, on the single write port; burst beats wait for the last one.
// Reads proceed while those writes drain, since they address the other bank.
// Reset clears all control state and presence bits at once; no clearing pass runs.
// A stalled result holds the request side only when a new beat would replace it.
module spi_burst_frame_reassembler
    import spibfr_pkg::*;
#(
    parameter int SLOT_COUNT     = 128,
    parameter int WORDS_PER_SLOT = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int WIDX_W    = (WORDS_PER_SLOT > 1) ? $clog2(WORDS_PER_SLOT) : 1;
    localparam int WCNT_W    = $clog2(WORDS_PER_SLOT + 1);
    localparam int ADDR_W    = 1 + SLOT_W + WIDX_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int GAP_W     = SLOT_W + 1;

    localparam logic [SLOT_IN_W:0]  SLOT_LIMIT = (SLOT_IN_W + 1)'(SLOT_COUNT);
    localparam logic [RWORD_IN_W:0] WORD_LIMIT = (RWORD_IN_W + 1)'(WORDS_PER_SLOT);
    localparam logic [GAP_W-1:0]    GAP_MOD    = GAP_W'(SLOT_COUNT);
    localparam logic [WCNT_W-1:0]   WCNT_FULL  = WCNT_W'(WORDS_PER_SLOT);
    localparam logic [WCNT_W-1:0]   WCNT_ONE   = WCNT_W'(1);

    // Control state.
    logic [SLOT_W-1:0] last_slot_reg, last_slot_next;
    logic              building_reg, building_next;
    logic [LOST_W-1:0] build_lost_reg, build_lost_next;
    logic [LOST_W-1:0] done_lost_reg, done_lost_next;
    logic              done_valid_reg, done_valid_next;
    logic              bank_sel_reg, bank_sel_next;
    logic [1:0][SLOT_COUNT-1:0] present_reg, present_next;

    // Pending word writes of the last stored burst.
    logic [WCNT_W-1:0]  wr_left_reg, wr_left_next;
    logic [WIDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic               wr_bank_reg, wr_bank_next;
    logic [SLOT_W-1:0]  wr_slot_reg, wr_slot_next;
    logic [WORD_W-1:0]  wbuf_reg [WORDS_PER_SLOT];
    logic [WORD_W-1:0]  wbuf_next [WORDS_PER_SLOT];

    // Result stage; read_data is merged from the memory output.
    logic               s1_valid_reg, s1_valid_next;
    rsp_t               s1_reg, s1_next;
    logic               s1_use_mem_reg, s1_use_mem_next;

    // Frame word memory.
    logic [WORD_W-1:0]  mem [MEM_DEPTH];
    logic [WORD_W-1:0]  mem_q_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;

    logic               accept;
    logic [WORD_W-1:0]  hdr;
    logic [SLOT_IN_W-1:0] hdr_addr;
    logic [SLOT_W-1:0]  addr_s;
    logic [SLOT_W-1:0]  rslot_s;
    logic [3:0][WORD_W-1:0] din;
    logic               close;
    logic               bank_new;
    logic               starting;
    logic [LOST_W-1:0]  lost_base;
    logic [GAP_W-1:0]   gap_raw;
    logic [GAP_W-1:0]   gap;
    logic [LOST_W:0]    lost_sum;
    logic               rd_hit;

    assign req_stall = (s1_valid_reg && rsp_stall) ||
                       (req.op == OP_BURST && wr_left_reg > WCNT_ONE);
    assign accept    = req_valid && !req_stall;

    assign hdr      = swap_bytes(req.header_raw);
    assign hdr_addr = hdr[HDR_ADDR_HI:HDR_ADDR_LO];
    assign addr_s   = hdr_addr[SLOT_W-1:0];
    assign rslot_s  = req.read_slot[SLOT_W-1:0];
    assign din      = {swap_bytes(req.data_raw_d), swap_bytes(req.data_raw_c),
                       swap_bytes(req.data_raw_b), swap_bytes(req.data_raw_a)};

    assign close     = (addr_s < last_slot_reg) && building_reg;
    assign bank_new  = bank_sel_reg ^ close;
    assign starting  = !building_reg || close;
    assign lost_base = starting ? '0 : build_lost_reg;

    // Modular gap between consecutive stored addresses; zero when contiguous.
    assign gap_raw  = GAP_W'(addr_s) + GAP_MOD - GAP_W'(last_slot_reg) - GAP_W'(1);
    assign gap      = (gap_raw >= GAP_MOD) ? gap_raw - GAP_MOD : gap_raw;
    assign lost_sum = (LOST_W + 1)'(lost_base) + (LOST_W + 1)'(gap);

    assign rd_hit = done_valid_reg &&
                    ({1'b0, req.read_slot} < SLOT_LIMIT) &&
                    ({1'b0, req.read_word} < WORD_LIMIT) &&
                    present_reg[!bank_sel_reg][rslot_s];

    assign rd_en   = accept && req.op == OP_READ;
    assign rd_addr = {!bank_sel_reg, rslot_s, req.read_word[WIDX_W-1:0]};
    assign wr_en   = wr_left_reg != '0;
    assign wr_addr = {wr_bank_reg, wr_slot_reg, wr_idx_reg};

    always_comb
    begin
        last_slot_next  = last_slot_reg;
        building_next   = building_reg;
        build_lost_next = build_lost_reg;
        done_lost_next  = done_lost_reg;
        done_valid_next = done_valid_reg;
        bank_sel_next   = bank_sel_reg;
        present_next    = present_reg;
        wr_bank_next    = wr_bank_reg;
        wr_slot_next    = wr_slot_reg;
        s1_next         = s1_reg;
        s1_use_mem_next = s1_use_mem_reg;
        s1_valid_next   = s1_valid_reg && rsp_stall;

        // Drain one pending word per cycle.
        wr_left_next = wr_left_reg;
        wr_idx_next  = wr_idx_reg;
        for (int i = 0; i < WORDS_PER_SLOT; i++) begin
            wbuf_next[i] = wbuf_reg[i];
        end
        if (wr_en) begin
            wr_left_next = wr_left_reg - WCNT_ONE;
            wr_idx_next  = wr_idx_reg + WIDX_W'(1);
            for (int i = 0; i < WORDS_PER_SLOT - 1; i++) begin
                wbuf_next[i] = wbuf_reg[i + 1];
            end
        end

        if (accept) begin
            s1_valid_next        = 1'b1;
            s1_use_mem_next      = 1'b0;
            s1_next.frame_done   = 1'b0;
            s1_next.read_data    = '0;
            s1_next.read_present = 1'b0;
            if (req.op == OP_READ) begin
                s1_next.status       = ST_READ;
                s1_next.read_present = rd_hit;
                s1_use_mem_next      = rd_hit;
            end else if (!hdr[HDR_WRITE_BIT]) begin
                s1_next.status = ST_IGNORED;
            end else if ({1'b0, hdr_addr} >= SLOT_LIMIT) begin
                s1_next.status = ST_DROPPED;
            end else begin
                s1_next.status     = ST_STORED;
                s1_next.frame_done = close;
                if (close) begin
                    done_lost_next  = build_lost_reg;
                    done_valid_next = 1'b1;
                end
                bank_sel_next = bank_new;
                if (starting) begin
                    present_next[bank_new] = '0;
                end
                present_next[bank_new][addr_s] = 1'b1;
                build_lost_next = lost_sum[LOST_W] ? LOST_MAX : lost_sum[LOST_W-1:0];
                building_next   = 1'b1;
                last_slot_next  = addr_s;
                wr_left_next    = WCNT_FULL;
                wr_idx_next     = '0;
                wr_bank_next    = bank_new;
                wr_slot_next    = addr_s;
                for (int i = 0; i < WORDS_PER_SLOT; i++) begin
                    wbuf_next[i] = din[i];
                end
            end
            s1_next.frame_lost  = done_lost_next;
            s1_next.frame_ready = done_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_slot_reg  <= '0;
            building_reg   <= 1'b0;
            build_lost_reg <= '0;
            done_lost_reg  <= '0;
            done_valid_reg <= 1'b0;
            bank_sel_reg   <= 1'b0;
            present_reg    <= '0;
            wr_left_reg    <= '0;
            wr_idx_reg     <= '0;
            s1_valid_reg   <= 1'b0;
        end else begin
            last_slot_reg  <= last_slot_next;
            building_reg   <= building_next;
            build_lost_reg <= build_lost_next;
            done_lost_reg  <= done_lost_next;
            done_valid_reg <= done_valid_next;
            bank_sel_reg   <= bank_sel_next;
            present_reg    <= present_next;
            wr_left_reg    <= wr_left_next;
            wr_idx_reg     <= wr_idx_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_bank_reg    <= wr_bank_next;
        wr_slot_reg    <= wr_slot_next;
        s1_reg         <= s1_next;
        s1_use_mem_reg <= s1_use_mem_next;
        for (int i = 0; i < WORDS_PER_SLOT; i++) begin
            wbuf_reg[i] <= wbuf_next[i];
        end
    end

    // Writes always target the bank being built; reads the completed bank.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wbuf_reg[0];
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        rsp = s1_reg;
        rsp.read_data = s1_use_mem_reg ? mem_q_reg : '0;
    end
    assign rsp_valid = s1_valid_reg;

    a_burst_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == OP_BURST) |-> (wr_left_reg <= WCNT_ONE))
        else $error("burst beat taken while frame words still pending");

    a_write_to_build_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_left_reg != '0) |-> (wr_bank_reg == bank_sel_reg))
        else $error("pending write targets the readable bank");

    a_present_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.read_present) |-> (rsp.frame_ready && rsp.status == ST_READ))
        else $error("read reports a present slot without a completed frame");

    a_done_is_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == OP_BURST && close && hdr[HDR_WRITE_BIT] &&
         {1'b0, hdr_addr} < SLOT_LIMIT) |=> (done_valid_reg && bank_sel_reg != $past(bank_sel_reg)))
        else $error("frame close did not switch banks");

endmodule

[bench/spi_burst_frame_reassembler_test.sv]
// Self-checking bench for spi_burst_frame_reassembler: a clocked driver and monitor,
// a behavioral frame predictor and directed plus random burst and read traffic.
// Depends on spibfr_pkg and the reassembler RTL.
module spi_burst_frame_reassembler_test
    import spibfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 128;
    localparam int SLOT_WORDS = 4;
    localparam int ITEM_GOAL  = 850;
    localparam int CYCLE_CAP  = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t pending_beats[$];
    rsp_t expected_results[$];
    int   fail_count = 0;
    int   cycle_count = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    bit   calm = 1'b0;

    // Predictor copy of the block state.
    int unsigned       last_addr;
    bit                frame_open;
    logic [LOST_W-1:0] open_lost;
    logic [LOST_W-1:0] closed_lost;
    bit                closed_avail;
    bit                build_bank;
    bit                slot_seen [0:1][0:SLOTS-1];
    logic [63:0]       slot_data [0:1][0:SLOTS-1][0:SLOT_WORDS-1];

    spi_burst_frame_reassembler #(
        .SLOT_COUNT     (SLOTS),
        .WORDS_PER_SLOT (SLOT_WORDS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5ns clk = ~clk;

    function automatic logic [63:0] byte_reverse(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < 8; k++)
        begin
            r = {r[55:0], v[8*k +: 8]};
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // The raw header carries the store flag and address in its lowest byte,
    // which the swap moves to the top.
    function automatic req_t make_burst(input bit store, input logic [6:0] addr);
        req_t b;
        b.op         = OP_BURST;
        b.header_raw = rand_word();
        b.header_raw[7:0] = {store, addr};
        b.data_raw_a = rand_word();
        b.data_raw_b = rand_word();
        b.data_raw_c = rand_word();
        b.data_raw_d = rand_word();
        b.read_slot  = 7'($urandom);
        b.read_word  = 2'($urandom);
        return b;
    endfunction

    function automatic req_t make_read(input logic [6:0] slot, input logic [1:0] word);
        req_t b;
        b = make_burst(1'($urandom_range(0, 1)), 7'($urandom));
        b.op        = OP_READ;
        b.read_slot = slot;
        b.read_word = word;
        return b;
    endfunction

    task automatic predict_reassembly(input req_t r);
        rsp_t        e;
        logic [63:0] hdr;
        logic [63:0] dw [4];
        int unsigned addr;
        int unsigned gap;
        int unsigned sum;
        bit          rd_bank;
        e = '0;
        if (r.op == OP_READ)
        begin
            e.status = ST_READ;
            rd_bank = ~build_bank;
            if (closed_avail && r.read_slot < SLOTS && r.read_word < SLOT_WORDS &&
                slot_seen[rd_bank][r.read_slot])
            begin
                e.read_present = 1'b1;
                e.read_data = slot_data[rd_bank][r.read_slot][r.read_word];
            end
        end
        else
        begin
            hdr = byte_reverse(r.header_raw);
            if (!hdr[HDR_WRITE_BIT])
            begin
                e.status = ST_IGNORED;
            end
            else
            begin
                addr = 32'(hdr[HDR_ADDR_HI:HDR_ADDR_LO]);
                if (addr >= SLOTS)
                begin
                    e.status = ST_DROPPED;
                end
                else
                begin
                    // A lower address closes the frame under construction.
                    if (addr < last_addr && frame_open)
                    begin
                        closed_lost  = open_lost;
                        closed_avail = 1'b1;
                        build_bank   = ~build_bank;
                        frame_open   = 1'b0;
                        e.frame_done = 1'b1;
                    end
                    if (!frame_open)
                    begin
                        for (int s = 0; s < SLOTS; s++)
                        begin
                            slot_seen[build_bank][s] = 1'b0;
                        end
                        open_lost  = '0;
                        frame_open = 1'b1;
                    end
                    if ((last_addr + 1) % SLOTS != addr)
                    begin
                        gap = (addr + SLOTS - last_addr - 1) % SLOTS;
                        sum = open_lost + gap;
                        open_lost = (sum > LOST_MAX) ? LOST_MAX : sum[LOST_W-1:0];
                    end
                    dw[0] = r.data_raw_a;
                    dw[1] = r.data_raw_b;
                    dw[2] = r.data_raw_c;
                    dw[3] = r.data_raw_d;
                    slot_seen[build_bank][addr] = 1'b1;
                    for (int w = 0; w < SLOT_WORDS; w++)
                    begin
                        slot_data[build_bank][addr][w] = byte_reverse(dw[w]);
                    end
                    last_addr = addr;
                    e.status = ST_STORED;
                end
            end
        end
        e.frame_lost  = closed_lost;
        e.frame_ready = closed_avail;
        expected_results.push_back(e);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Request driver: holds a beat until it is taken, then predicts its result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            calm <= (pending_beats.size() < 100);
            if (req_valid && !req_stall)
            begin
                predict_reassembly(req);
            end
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    req_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_beats.size() > 0)
                begin
                    req <= pending_beats.pop_front();
                    req_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 18);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_results.pop_front();
                    check_field("status", e.status, rsp.status);
                    check_field("frame_done", e.frame_done, rsp.frame_done);
                    check_field("frame_lost", e.frame_lost, rsp.frame_lost);
                    check_field("frame_ready", e.frame_ready, rsp.frame_ready);
                    check_field("read_data", e.read_data, rsp.read_data);
                    check_field("read_present", e.read_present, rsp.read_present);
                end
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                rsp_stall <= 1'b1;
                stall_left <= $urandom_range(0, 17);
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        req_t        b;
        int          counted;
        int unsigned gen_last;
        int unsigned cur_addr;
        int          frame_len;
        logic [6:0]  prev_slots[$];
        logic [6:0]  cur_slots[$];

        last_addr    = 0;
        frame_open   = 1'b0;
        open_lost    = '0;
        closed_lost  = '0;
        closed_avail = 1'b0;
        build_bank   = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_seen[0][s] = 1'b0;
            slot_seen[1][s] = 1'b0;
        end

        // Directed part: read before any frame, an unflagged burst, extreme data,
        // repeated addresses driving the lost count to saturation, frame closes.
        pending_beats.push_back(make_read(7'd5, 2'd0));
        b = make_burst(1'b0, 7'h7F);
        b.header_raw = 64'hFFFF_FFFF_FFFF_FF7F;
        pending_beats.push_back(b);
        b = make_burst(1'b1, 7'd5);
        b.header_raw = 64'h0000_0000_0000_0085;
        b.data_raw_a = '1;
        b.data_raw_b = '0;
        b.data_raw_c = 64'h0123_4567_89AB_CDEF;
        b.data_raw_d = 64'hAAAA_5555_AAAA_5555;
        pending_beats.push_back(b);
        pending_beats.push_back(make_burst(1'b1, 7'd6));
        pending_beats.push_back(make_burst(1'b1, 7'd7));
        pending_beats.push_back(make_burst(1'b1, 7'd7));
        pending_beats.push_back(make_burst(1'b1, 7'd7));
        b = make_burst(1'b1, 7'd127);
        b.header_raw = '1;
        b.data_raw_a = '0;
        b.data_raw_b = '1;
        pending_beats.push_back(b);
        pending_beats.push_back(make_read(7'd5, 2'd0));
        pending_beats.push_back(make_burst(1'b1, 7'd0));
        pending_beats.push_back(make_read(7'd5, 2'd0));
        pending_beats.push_back(make_read(7'd5, 2'd3));
        pending_beats.push_back(make_read(7'd7, 2'd1));
        pending_beats.push_back(make_read(7'd127, 2'd2));
        pending_beats.push_back(make_read(7'd6, 2'd3));
        pending_beats.push_back(make_read(7'd0, 2'd0));
        pending_beats.push_back(make_read(7'd100, 2'd1));
        pending_beats.push_back(make_burst(1'b1, 7'd3));
        pending_beats.push_back(make_burst(1'b1, 7'd1));
        pending_beats.push_back(make_read(7'd3, 2'd2));
        pending_beats.push_back(make_read(7'd0, 2'd3));
        pending_beats.push_back(make_read(7'd127, 2'd0));
        gen_last = 1;
        counted  = 0;
        prev_slots = {};
        cur_slots  = {7'd1};

        // Random part: mostly ascending frames closed by a lower address, with
        // reads of the frame just closed, unflagged noise and stray bursts.
        while (counted < ITEM_GOAL)
        begin
            cur_addr = (gen_last > 0) ? $urandom_range(0, gen_last - 1) : 0;
            pending_beats.push_back(make_burst(1'b1, cur_addr[6:0]));
            counted++;
            prev_slots = cur_slots;
            cur_slots  = {cur_addr[6:0]};
            repeat ($urandom_range(1, 6))
            begin
                if (prev_slots.size() > 0 && $urandom_range(0, 3) != 0)
                    pending_beats.push_back(make_read(
                        prev_slots[$urandom_range(0, prev_slots.size() - 1)],
                        2'($urandom)));
                else
                    pending_beats.push_back(make_read(7'($urandom), 2'($urandom)));
                counted++;
            end
            frame_len = $urandom_range(0, 12);
            for (int i = 0; i < frame_len; i++)
            begin
                case ($urandom_range(0, 19))
                    0, 1:
                    begin
                        pending_beats.push_back(make_burst(1'b0, 7'($urandom)));
                        counted++;
                    end
                    2, 3:
                    begin
                        pending_beats.push_back(make_read(7'($urandom), 2'($urandom)));
                        counted++;
                    end
                    4:
                    begin
                        cur_addr = $urandom_range(0, SLOTS - 1);
                        pending_beats.push_back(make_burst(1'b1, cur_addr[6:0]));
                        cur_slots.push_back(cur_addr[6:0]);
                        counted++;
                    end
                    default:
                    begin
                        case ($urandom_range(0, 9))
                            0:       cur_addr = cur_addr;
                            1, 2:    cur_addr = cur_addr + $urandom_range(2, 6);
                            3:       cur_addr = cur_addr + $urandom_range(7, 60);
                            default: cur_addr = cur_addr + 1;
                        endcase
                        if (cur_addr > SLOTS - 1)
                            cur_addr = SLOTS - 1;
                        pending_beats.push_back(make_burst(1'b1, cur_addr[6:0]));
                        cur_slots.push_back(cur_addr[6:0]);
                        counted++;
                    end
                endcase
            end
            gen_last = cur_addr;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() > 0 || req_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/spibfr_pkg.sv
hw/rtl/spi_burst_frame_reassembler.sv
bench/spi_burst_frame_reassembler_test.sv
